// File: sv/address_to_symbol_range_lookup_macros.svh
// Assertion macros for the region table lookup RTL.
`ifndef ADDRESS_TO_SYMBOL_RANGE_LOOKUP_MACROS_SVH
`define ADDRESS_TO_SYMBOL_RANGE_LOOKUP_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while in reset
`define ASRL_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while in reset
`define ASRL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASRL_ASSERT(lbl, clk, rst_n, ante, cons, msg)
`define ASRL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: sv/asrl_pkg.sv
// Package: types, codes and defaults for the region table lookup.
`default_nettype none
package asrl_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 256;
    localparam int ADDR_W = 64;
    localparam int INDEX_OUT_W = 8;

    // Request kinds
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        STAT_INSERTED = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_HIT      = 2'd2,
        STAT_MISS     = 2'd3
    } status_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } state_t;

    // One stored region as read back from the table
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] length;
        logic              func_flag;
    } entry_t;

    // Status of the compare unit back to the sequencer
    typedef struct packed {
        logic found;
        logic busy;
    } scan_status_t;

endpackage
`default_nettype wire

// File: sv/address_to_symbol_range_lookup.sv
// Top level: region table with greatest-start address lookup.
//
// Holds up to TABLE_DEPTH regions (start, length, function flag) in one RAM.
// An insert answers "inserted" or "table full" in the cycle after it is taken;
// a lookup scans the stored regions in insertion order through a single RAM
// read port and one shared compare unit, one region per cycle, and answers
// once the last region has passed the RAM read and both compare stages.
// Among function regions that hold the address, the greatest start wins and
// the earlier region wins a tie; a length of zero means no upper bound. One
// request is worked on at a time: s_ready is high only when the block is
// idle and the previous result has been taken. match_index carries the low
// 8 bits of the region index. The table needs no clearing after reset.
`default_nettype none
`include "address_to_symbol_range_lookup_macros.svh"
module address_to_symbol_range_lookup
    import asrl_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_action,
    input  wire logic [ADDR_W-1:0] s_address,
    input  wire logic [ADDR_W-1:0] s_entry_size,
    input  wire logic              s_func_flag,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [1:0]             m_status,
    output logic [INDEX_OUT_W-1:0] m_match_index,
    output logic [ADDR_W-1:0]      m_match_start,
    output logic [ADDR_W-1:0]      m_match_size
);

    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int WORD_W = 2 * ADDR_W + 1;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  issue_reg, issue_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic              rd_v_reg;
    logic [IDX_W-1:0]  rd_idx_reg;

    logic                   m_valid_reg, m_valid_next;
    status_t                m_status_reg, m_status_next;
    logic [INDEX_OUT_W-1:0] m_index_reg, m_index_next;
    logic [ADDR_W-1:0]      m_start_reg, m_start_next;
    logic [ADDR_W-1:0]      m_size_reg, m_size_next;

    logic              accept;
    logic              is_full;
    logic              ram_we;
    logic              rd_en;
    logic              scan_done;
    logic              clear;
    logic [WORD_W-1:0] ram_wdata;
    logic [WORD_W-1:0] ram_rdata;
    entry_t            entry;
    scan_status_t      stat;
    logic [IDX_W-1:0]  best_idx;
    logic [ADDR_W-1:0] best_start;
    logic [ADDR_W-1:0] best_length;
    logic [INDEX_OUT_W-1:0] best_idx8;

    assign s_ready   = (state_reg == ST_IDLE) && !m_valid_reg;
    assign accept    = s_valid && s_ready;
    assign is_full   = (count_reg == DEPTH_CNT);
    assign ram_we    = accept && (s_action == ACT_INSERT) && !is_full;
    assign clear     = accept && (s_action == ACT_LOOKUP);
    assign ram_wdata = {s_address, s_entry_size, s_func_flag};
    assign rd_en     = (state_reg == ST_SCAN) && (issue_reg < count_reg);
    assign scan_done = (state_reg == ST_SCAN) && (issue_reg == count_reg) &&
                       !rd_v_reg && !stat.busy;

    // region table
    asrl_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (ram_wdata),
        .re    (rd_en),
        .raddr (issue_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign entry.valid     = rd_v_reg;
    assign entry.start     = ram_rdata[WORD_W-1 -: ADDR_W];
    assign entry.length    = ram_rdata[ADDR_W:1];
    assign entry.func_flag = ram_rdata[0];

    // shared compare unit
    asrl_match #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_match (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .clear       (clear),
        .query_addr  (addr_reg),
        .entry       (entry),
        .entry_idx   (rd_idx_reg),
        .stat        (stat),
        .best_idx    (best_idx),
        .best_start  (best_start),
        .best_length (best_length)
    );

    // low bits of the winning index for the result
    generate
        if (IDX_W >= INDEX_OUT_W) begin : g_idx_trunc
            assign best_idx8 = best_idx[INDEX_OUT_W-1:0];
        end else begin : g_idx_ext
            assign best_idx8 = {{(INDEX_OUT_W - IDX_W){1'b0}}, best_idx};
        end
    endgenerate

    // sequencer and result register
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        issue_next    = issue_reg;
        addr_next     = addr_reg;
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_index_next  = m_index_reg;
        m_start_next  = m_start_reg;
        m_size_next   = m_size_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_action == ACT_INSERT) begin
                        m_valid_next = 1'b1;
                        m_index_next = '0;
                        m_start_next = '0;
                        m_size_next  = '0;
                        if (is_full) begin
                            m_status_next = STAT_FULL;
                        end else begin
                            m_status_next = STAT_INSERTED;
                            count_next    = count_reg + CNT_W'(1);
                        end
                    end else begin
                        addr_next  = s_address;
                        issue_next = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (rd_en) begin
                    issue_next = issue_reg + CNT_W'(1);
                end
                if (scan_done) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                    if (stat.found) begin
                        m_status_next = STAT_HIT;
                        m_index_next  = best_idx8;
                        m_start_next  = best_start;
                        m_size_next   = best_length;
                    end else begin
                        m_status_next = STAT_MISS;
                        m_index_next  = '0;
                        m_start_next  = '0;
                        m_size_next   = '0;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            rd_v_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            rd_v_reg    <= rd_en;
        end
    end

    always_ff @(posedge aclk) begin
        issue_reg    <= issue_next;
        addr_reg     <= addr_next;
        rd_idx_reg   <= issue_reg[IDX_W-1:0];
        m_status_reg <= m_status_next;
        m_index_reg  <= m_index_next;
        m_start_reg  <= m_start_next;
        m_size_reg   <= m_size_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_match_index = m_index_reg;
    assign m_match_start = m_start_reg;
    assign m_match_size  = m_size_reg;

    // checks on the table and the scan
    `ASRL_ASSERT(a_count_bound, aclk, aresetn, 1'b1, count_reg <= DEPTH_CNT,
        "entry count above table depth")
    `ASRL_ASSERT(a_write_room, aclk, aresetn, ram_we, count_reg < DEPTH_CNT,
        "table written while full")
    `ASRL_ASSERT_NEXT(a_done_result, aclk, aresetn, scan_done,
        m_valid_reg && ((m_status_reg == STAT_HIT) || (m_status_reg == STAT_MISS)),
        "finished scan did not post a lookup result")
    `ASRL_ASSERT(a_hit_below, aclk, aresetn, m_valid_reg && (m_status_reg == STAT_HIT),
        m_start_reg <= addr_reg, "hit region starts above the queried address")
    `ASRL_ASSERT(a_scan_in_range, aclk, aresetn, state_reg == ST_SCAN,
        issue_reg <= count_reg, "scan ran past the stored entries")

endmodule
`default_nettype wire

// File: sv/asrl_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module asrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   aclk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// File: sv/asrl_match.sv
// Shared compare unit: tests one region per cycle and keeps the best match.
`default_nettype none
module asrl_match
    import asrl_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  wire logic                                               aclk,
    input  wire logic                                               aresetn,
    input  wire logic                                               clear,
    input  wire logic [ADDR_W-1:0]                                  query_addr,
    input  wire entry_t                                             entry,
    input  wire logic [(TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1)-1:0] entry_idx,
    output scan_status_t                                            stat,
    output logic [(TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1)-1:0]  best_idx,
    output logic [ADDR_W-1:0]                                       best_start,
    output logic [ADDR_W-1:0]                                       best_length
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // stage A: containment test
    logic              hit_v_reg, hit_v_next;
    logic              hit_reg, hit_next;
    logic [IDX_W-1:0]  hit_idx_reg;
    logic [ADDR_W-1:0] hit_start_reg;
    logic [ADDR_W-1:0] hit_length_reg;
    logic [ADDR_W-1:0] offset;

    // stage B: running best
    logic              found_reg, found_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    logic [ADDR_W-1:0] best_start_reg, best_start_next;
    logic [ADDR_W-1:0] best_length_reg, best_length_next;
    logic              take;

    // region holds the address: start <= addr and, if bounded, addr - start < length
    always_comb begin
        offset     = query_addr - entry.start;
        hit_v_next = entry.valid && !clear;
        hit_next   = entry.func_flag && (entry.start <= query_addr) &&
                     ((entry.length == '0) || (offset < entry.length));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_v_reg <= 1'b0;
        end else begin
            hit_v_reg <= hit_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        hit_reg        <= hit_next;
        hit_idx_reg    <= entry_idx;
        hit_start_reg  <= entry.start;
        hit_length_reg <= entry.length;
    end

    // greatest start wins; strict compare keeps the earlier region on a tie
    always_comb begin
        take             = hit_v_reg && hit_reg && (!found_reg || (hit_start_reg > best_start_reg));
        found_next       = found_reg;
        best_idx_next    = best_idx_reg;
        best_start_next  = best_start_reg;
        best_length_next = best_length_reg;
        if (clear) begin
            found_next = 1'b0;
        end else if (take) begin
            found_next       = 1'b1;
            best_idx_next    = hit_idx_reg;
            best_start_next  = hit_start_reg;
            best_length_next = hit_length_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge aclk) begin
        best_idx_reg    <= best_idx_next;
        best_start_reg  <= best_start_next;
        best_length_reg <= best_length_next;
    end

    assign stat.found  = found_reg;
    assign stat.busy   = hit_v_reg;
    assign best_idx    = best_idx_reg;
    assign best_start  = best_start_reg;
    assign best_length = best_length_reg;

endmodule
`default_nettype wire
